// ===== design/crtc_pkg.sv =====
// Package for the CRT controller line timing block.
// Holds bus codes and the structs shared by the top level and the timing unit.
// No dependencies.
`default_nettype none

package crtc_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [3:0] PORT_INDEX  = 4'd4;
  localparam logic [3:0] PORT_DATA   = 4'd5;
  localparam logic [3:0] PORT_STATUS = 4'd10;

  localparam logic [7:0] READ_UNKNOWN = 8'hff;

  localparam int NumRegs  = 32;
  localparam int RegIdxW  = 5;

  localparam logic [4:0] REG_CURSOR_HI = 5'd14;
  localparam logic [4:0] REG_CURSOR_LO = 5'd15;

  // register fields that drive the scan timing
  typedef struct packed {
    logic [7:0]  h_displayed;   // register 1
    logic [3:0]  vsync_width;   // register 3, upper nibble
    logic [6:0]  v_total;       // register 4
    logic [4:0]  v_adjust;      // register 5
    logic [6:0]  v_displayed;   // register 6
    logic [6:0]  vsync_pos;     // register 7
    logic [1:0]  interlace;     // register 8, low bits
    logic [4:0]  max_row;       // register 9
    logic [6:0]  cursor_start;  // register 10
    logic [4:0]  cursor_end;    // register 11
    logic [13:0] start_addr;    // registers 12 and 13
  } tim_cfg_t;

  typedef struct packed {
    logic        disp_on;
    logic [15:0] addr_now;
    logic [4:0]  row_count;
    logic        cursor_line_on;
    logic        half_phase;
    logic        double_phase;
    logic        hblank;
    logic        vsync;
  } tim_view_t;

endpackage

`default_nettype wire

// ===== design/crtc_timing.sv =====
// Scan-line timing unit: row, character-row, adjust, vsync and cursor counters.
// Advances once per half-line tick. Depends on crtc_pkg.
`default_nettype none

module crtc_timing
  import crtc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      tick,
  input  wire tim_cfg_t  cfg,
  output tim_view_t      view_next,
  output tim_view_t      view
);

  typedef struct packed {
    logic        hblank;
    logic        vsync;
    logic        half_phase;
    logic        double_phase;
    logic [4:0]  row_count;
    logic [6:0]  char_row_count;
    logic [4:0]  adjust_left;
    logic [4:0]  vsync_left;
    logic [15:0] addr_now;
    logic [15:0] addr_row_start;
    logic        disp_on;
    logic        cursor_window;
    logic        cursor_blink_on;
    logic [4:0]  blink_count;
  } tim_state_t;

  tim_state_t st;
  tim_state_t st_next;

  function automatic logic row_match(logic [4:0] row, logic [4:0] limit, logic dbl);
    return (row == limit) || (dbl && (row == {1'b0, limit[4:1]}));
  endfunction

  always_comb begin
    logic       dbl;
    logic [6:0] prev;
    dbl     = (cfg.interlace == 2'b11);
    prev    = st.char_row_count;
    st_next = st;
    if (tick) begin
      if (st.half_phase) begin
        if (st.disp_on) st_next.hblank = 1'b0;
        st_next.half_phase   = 1'b0;
        st_next.double_phase = ~st.double_phase;
        if (!st.double_phase) begin
          st_next.addr_now = st.addr_row_start;
        end else begin
          if (st.vsync_left != 5'd0) begin
            st_next.vsync_left = st.vsync_left - 5'd1;
            if (st.vsync_left == 5'd1) st_next.vsync = 1'b0;
          end
          if (row_match(st.row_count, cfg.cursor_end, dbl)) st_next.cursor_window = 1'b0;

          if (st.adjust_left != 5'd0) begin
            st_next.row_count   = st.row_count + 5'd1;
            st_next.addr_now    = st.addr_row_start;
            st_next.adjust_left = st.adjust_left - 5'd1;
            if (st.adjust_left == 5'd1) begin
              st_next.disp_on        = 1'b1;
              st_next.addr_now       = {2'b00, cfg.start_addr};
              st_next.addr_row_start = {2'b00, cfg.start_addr};
              st_next.row_count      = 5'd0;
            end
          end else if (row_match(st.row_count, cfg.max_row, dbl)) begin
            st_next.addr_row_start = st.addr_now;
            st_next.row_count      = 5'd0;
            st_next.char_row_count = st.char_row_count + 7'd1;
            if (st_next.char_row_count == cfg.v_displayed) st_next.disp_on = 1'b0;
            if (prev == cfg.v_total) begin
              st_next.char_row_count = 7'd0;
              st_next.adjust_left    = cfg.v_adjust;
              if (cfg.v_adjust == 5'd0) begin
                st_next.disp_on        = 1'b1;
                st_next.addr_now       = {2'b00, cfg.start_addr};
                st_next.addr_row_start = {2'b00, cfg.start_addr};
              end
              if (cfg.cursor_start[6:5] == 2'b01) begin
                st_next.cursor_blink_on = 1'b0;
              end else begin
                st_next.cursor_blink_on = st.blink_count[4];
              end
            end
            if (st_next.char_row_count == cfg.vsync_pos) begin
              st_next.disp_on     = 1'b0;
              st_next.vsync_left  = {1'b0, cfg.vsync_width} + 5'd1;
              st_next.blink_count = st.blink_count + 5'd1;
            end
          end else begin
            st_next.row_count = st.row_count + 5'd1;
            st_next.addr_now  = st.addr_row_start;
          end

          if (row_match(st_next.row_count, cfg.cursor_start[4:0], dbl)) begin
            st_next.cursor_window = 1'b1;
          end
        end
      end else begin
        st_next.hblank     = 1'b1;
        st_next.half_phase = 1'b1;
        if (st.disp_on) st_next.addr_now = st.addr_now + {8'h00, cfg.h_displayed};
        if ((st.char_row_count == cfg.vsync_pos) && (st.row_count == 5'd0)) begin
          st_next.vsync = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    view_next.disp_on        = st_next.disp_on;
    view_next.addr_now       = st_next.addr_now;
    view_next.row_count      = st_next.row_count;
    view_next.cursor_line_on = st_next.cursor_window & st_next.cursor_blink_on;
    view_next.half_phase     = st_next.half_phase;
    view_next.double_phase   = st_next.double_phase;
    view_next.hblank         = st_next.hblank;
    view_next.vsync          = st_next.vsync;
    view.disp_on             = st.disp_on;
    view.addr_now            = st.addr_now;
    view.row_count           = st.row_count;
    view.cursor_line_on      = st.cursor_window & st.cursor_blink_on;
    view.half_phase          = st.half_phase;
    view.double_phase        = st.double_phase;
    view.hblank              = st.hblank;
    view.vsync               = st.vsync;
  end

`ifndef SYNTHESIS
  a_half_toggles: assert property (@(posedge clk) disable iff (rst)
    tick |=> (st.half_phase != $past(st.half_phase)))
    else $error("half phase did not alternate on a tick");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !tick |=> ($stable(st.addr_now) && $stable(st.row_count) && $stable(st.char_row_count)))
    else $error("timing state moved without a tick");

  a_display_half_hblank: assert property (@(posedge clk) disable iff (rst)
    (tick && !st.half_phase) |=> st.hblank)
    else $error("display half did not raise hblank");
`endif

endmodule

`default_nettype wire

// ===== design/crt_controller_line_timing.sv =====
// CRT controller line timing, top level: register file, bus decode and output buffer.
// Instantiates crtc_timing; depends on crtc_pkg.
//
// Usage:
//   Requests enter on the s_ channel: s_tuser carries the action (bus write,
//   bus read, half-line tick), s_tdata the port offset and the write byte.
//   Every accepted request gives exactly one result on the m_ channel with the
//   read byte and the timing outputs as they stand after that request.
//   Each result is registered. One request is taken per cycle while s_tready
//   is high: all per-request work is a single pass of decode and counter
//   logic into the result register.
//   Results wait in a two-entry buffer (result register plus skid register).
//   When the receiver stalls, one more request is taken into the skid slot,
//   then s_tready drops until the receiver takes a result.
//   Reset (rst, synchronous) clears all registers, the index and all counters
//   and empties the result buffer.
//   Port offsets: 4 index, 5 data, 10 status (reads only). Writes to other
//   ports are dropped; reads of other ports return 8'hff.
`default_nettype none

module crt_controller_line_timing
  import crtc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // port[3:0], write_data[11:4], zero fill
  input  wire logic [1:0]  s_tuser,   // action[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata    // read_data[7:0], display_enable[8], mem_addr[24:9],
                                      // row_addr[29:25], cursor_line_on[30],
                                      // cursor_addr[44:31], line_half[45], line_double[46],
                                      // hblank[47], vsync[48], zero fill
);

  localparam logic [7:0] RegMask [NumRegs] = '{
    8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h1f, 8'h7f, 8'h7f,
    8'hf3, 8'h1f, 8'h7f, 8'h1f, 8'h3f, 8'hff, 8'h3f, 8'hff,
    8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  logic [7:0]         crtc_regs [NumRegs];
  logic [RegIdxW-1:0] reg_index;

  logic        accept;
  action_t     action;
  logic [3:0]  port;
  logic [7:0]  write_data;
  logic [7:0]  read_data;
  logic        tick;
  tim_cfg_t    cfg;
  tim_view_t   view_next;
  tim_view_t   view;
  logic [7:0]  cursor_hi;
  logic [7:0]  cursor_lo;
  logic [13:0] cursor_addr;
  logic [55:0] result;

  logic        out_valid;
  logic [55:0] out_data;
  logic        skid_valid;
  logic [55:0] skid_data;

  assign accept     = s_tvalid && s_tready;
  assign action     = action_t'(s_tuser);
  assign port       = s_tdata[3:0];
  assign write_data = s_tdata[11:4];
  assign tick       = accept && (action == ACT_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_index <= '0;
      for (int i = 0; i < NumRegs; i++) crtc_regs[i] <= 8'h00;
    end else if (accept && (action == ACT_WRITE)) begin
      if (port == PORT_INDEX) begin
        reg_index <= write_data[RegIdxW-1:0];
      end else if (port == PORT_DATA) begin
        crtc_regs[reg_index] <= write_data & RegMask[reg_index];
      end
    end
  end

  always_comb begin
    cfg.h_displayed  = crtc_regs[1];
    cfg.vsync_width  = crtc_regs[3][7:4];
    cfg.v_total      = crtc_regs[4][6:0];
    cfg.v_adjust     = crtc_regs[5][4:0];
    cfg.v_displayed  = crtc_regs[6][6:0];
    cfg.vsync_pos    = crtc_regs[7][6:0];
    cfg.interlace    = crtc_regs[8][1:0];
    cfg.max_row      = crtc_regs[9][4:0];
    cfg.cursor_start = crtc_regs[10][6:0];
    cfg.cursor_end   = crtc_regs[11][4:0];
    cfg.start_addr   = {crtc_regs[12][5:0], crtc_regs[13]};
  end

  crtc_timing u_timing (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .cfg       (cfg),
    .view_next (view_next),
    .view      (view)
  );

  always_comb begin
    read_data = 8'h00;
    if (action == ACT_READ) begin
      unique case (port)
        PORT_INDEX:  read_data = {{(8-RegIdxW){1'b0}}, reg_index};
        PORT_DATA:   read_data = crtc_regs[reg_index];
        PORT_STATUS: read_data = {4'b0000, view.vsync, 2'b00, view.hblank};
        default:     read_data = READ_UNKNOWN;
      endcase
    end
  end

  // pass a data write to the cursor registers straight into this result
  always_comb begin
    cursor_hi = crtc_regs[REG_CURSOR_HI];
    cursor_lo = crtc_regs[REG_CURSOR_LO];
    if (accept && (action == ACT_WRITE) && (port == PORT_DATA)) begin
      if (reg_index == REG_CURSOR_HI) cursor_hi = write_data & RegMask[REG_CURSOR_HI];
      if (reg_index == REG_CURSOR_LO) cursor_lo = write_data & RegMask[REG_CURSOR_LO];
    end
  end

  assign cursor_addr = {cursor_hi[5:0], cursor_lo};

  assign result = {7'b0000000,
                   view_next.vsync,
                   view_next.hblank,
                   view_next.double_phase,
                   view_next.half_phase,
                   cursor_addr,
                   view_next.cursor_line_on,
                   view_next.row_count,
                   view_next.addr_now,
                   view_next.disp_on,
                   read_data};

  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full while result register empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && !m_tready) |=> skid_valid)
    else $error("request taken during stall was not buffered");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!out_valid && !skid_valid))
    else $error("result buffer not empty after reset");
`endif

endmodule

`default_nettype wire
